[design/pixel_tone_effect_engine_macros.svh]
// assertion macros for the pixel tone effect engine
`ifndef PIXEL_TONE_EFFECT_ENGINE_MACROS_SVH
`define PIXEL_TONE_EFFECT_ENGINE_MACROS_SVH

// checked only out of reset
`define PTE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("pte check failed");

// checked at every edge, reset included
`define PTE_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("pte check failed during reset");

`endif

[design/pte_pkg.sv]
// types, constants and color functions of the pixel tone effect engine
`timescale 1ns / 1ps
package pte_pkg;
	localparam int COORD_BITS = 12;
	localparam int CTR_W      = 11;
	localparam int AX_W       = (COORD_BITS > CTR_W) ? COORD_BITS : CTR_W;
	localparam int RATIO_W    = 17;
	localparam int SC_W       = AX_W + RATIO_W;
	localparam int SQ_W       = 2 * SC_W;
	localparam int D_W        = SQ_W + 1 - 32;
	localparam int REM_W      = D_W + 8;
	localparam int DIV_W      = 24;
	localparam int NCELL      = 9;
	localparam int NFRONT     = 4;
	localparam int NSTAGE     = NFRONT + NCELL;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [1:0] {
		MODE_PASS, MODE_FEATHER, MODE_SEPIA, MODE_WOODCUT
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE, CFG_CCOL, CFG_CROW, CFG_RATIO, CFG_SCALE, CFG_DIV
	} cfg_idx_t;

	localparam logic [CTR_W-1:0]   RST_CCOL  = 11'd320;
	localparam logic [CTR_W-1:0]   RST_CROW  = 11'd240;
	localparam logic [RATIO_W-1:0] RST_RATIO = 17'd49152;
	localparam logic [DIV_W-1:0]   RST_DIV   = 24'd80000;

	localparam logic [15:0] SEP_B_R = 16'd17826, SEP_B_G = 16'd34996, SEP_B_B = 16'd8585;
	localparam logic [15:0] SEP_G_R = 16'd22872, SEP_G_G = 16'd44958, SEP_G_B = 16'd11010;
	localparam logic [15:0] SEP_R_R = 16'd25756, SEP_R_G = 16'd50397, SEP_R_B = 16'd12386;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pte_rgb_t;

	typedef struct packed {
		pte_rgb_t         pix;
		pte_rgb_t         alt;
		logic [REM_W-1:0] rem;
		logic [7:0]       quo;
		logic             sat;
	} pte_item_t;

	function automatic logic [7:0] sepia_ch(input logic [15:0] kr, input logic [15:0] kg,
		input logic [15:0] kb, input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		logic [25:0] s;
		s = 26'(kr) * 26'(r) + 26'(kg) * 26'(g) + 26'(kb) * 26'(b);
		return (s[25:16] > 10'd255) ? 8'hFF : s[23:16];
	endfunction

	function automatic logic [7:0] woodcut(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		logic [21:0] l;
		l = 22'(r) * 22'd4899 + 22'(g) * 22'd9617 + 22'(b) * 22'd1868 + 22'd8192;
		return (l[21:14] > 8'd127) ? 8'hFF : 8'h00;
	endfunction
endpackage

[design/pte_pix_if.sv]
// input pixel channel
`timescale 1ns / 1ps
interface pte_pix_if import pte_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_col;
	logic [COORD_BITS-1:0] pixel_row;
	logic [7:0]            in_blue;
	logic [7:0]            in_green;
	logic [7:0]            in_red;
	modport source (output valid, pixel_col, pixel_row, in_blue, in_green, in_red,
		input ready);
	modport sink (input valid, pixel_col, pixel_row, in_blue, in_green, in_red,
		output ready);
endinterface

[design/pte_rgb_if.sv]
// output pixel channel
`timescale 1ns / 1ps
interface pte_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	modport source (output valid, out_blue, out_green, out_red, input ready);
	modport sink (input valid, out_blue, out_green, out_red, output ready);
endinterface

[design/pixel_tone_effect_engine.sv]
// top level: config registers, front stages, divider cell chain, output mix
// pipeline: 13 register stages (4 front, 9 cells)
// throughput: one pixel per cycle while the output is not stalled; one saturation cell, then one quotient bit per cell
// a stalled output holds its pixel; earlier stages keep filling their empty slots
// reset clears all valid bits and loads the config registers with their default values
`timescale 1ns / 1ps
module pixel_tone_effect_engine import pte_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	pte_pix_if.sink               pix_in,
	pte_rgb_if.source             pix_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);
	mode_t              mode_q;
	logic [CTR_W-1:0]   ccol_q, crow_q;
	logic [RATIO_W-1:0] ratio_q;
	logic               scale_q;
	logic [DIV_W-1:0]   div_q, div_eff;
	logic [NSTAGE:0]    en;
	logic [NSTAGE-1:0]  v;
	logic [NFRONT-1:0]  front_v;
	logic [NCELL:0]     cell_v;
	pte_item_t          cell_item [NCELL+1];
	pte_rgb_t           pix;
	pte_item_t          last;
	logic [7:0]         vig;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PASS;
			ccol_q  <= RST_CCOL;
			crow_q  <= RST_CROW;
			ratio_q <= RST_RATIO;
			scale_q <= 1'b1;
			div_q   <= RST_DIV;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:  mode_q  <= mode_t'(cfg_wdata[1:0]);
				CFG_CCOL:  ccol_q  <= cfg_wdata[CTR_W-1:0];
				CFG_CROW:  crow_q  <= cfg_wdata[CTR_W-1:0];
				CFG_RATIO: ratio_q <= cfg_wdata[RATIO_W-1:0];
				CFG_SCALE: scale_q <= cfg_wdata[0];
				CFG_DIV:   div_q   <= cfg_wdata[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	assign div_eff = (div_q == '0) ? DIV_W'(1) : div_q;

	assign v = {cell_v[NCELL:1], front_v};

	always_comb begin
		en[NSTAGE] = pix_out.ready;
		for (int i = NSTAGE - 1; i >= 0; i--) begin
			en[i] = ~v[i] | en[i+1];
		end
	end

	assign pix_in.ready = en[0];
	assign pix.blue     = pix_in.in_blue;
	assign pix.green    = pix_in.in_green;
	assign pix.red      = pix_in.in_red;

	pte_dist u_dist (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en[NFRONT-1:0]),
		.vin   (pix_in.valid),
		.col   (pix_in.pixel_col),
		.row   (pix_in.pixel_row),
		.pix   (pix),
		.mode  (mode_q),
		.ccol  (ccol_q),
		.crow  (crow_q),
		.ratio (ratio_q),
		.scale (scale_q),
		.vout  (front_v),
		.item  (cell_item[0])
	);

	assign cell_v[0] = front_v[NFRONT-1];

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		pte_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en[NFRONT+k]),
			.sat_cell(k == 0),
			.dsh     (REM_W'(div_eff) << (NCELL - 1 - ((k == 0) ? 0 : k))),
			.vin     (cell_v[k]),
			.din     (cell_item[k]),
			.vout    (cell_v[k+1]),
			.dout    (cell_item[k+1])
		);
	end

	assign last = cell_item[NCELL];
	assign vig  = last.sat ? 8'hFF : last.quo;

	function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

	assign pix_out.valid     = cell_v[NCELL];
	assign pix_out.out_blue  = (mode_q == MODE_FEATHER) ? sat_add(last.pix.blue, vig)
		: last.alt.blue;
	assign pix_out.out_green = (mode_q == MODE_FEATHER) ? sat_add(last.pix.green, vig)
		: last.alt.green;
	assign pix_out.out_red   = (mode_q == MODE_FEATHER) ? sat_add(last.pix.red, vig)
		: last.alt.red;
endmodule

[design/pte_dist.sv]
// front stages: centre offsets, aspect scaling, squares and scaled distance
`timescale 1ns / 1ps
module pte_dist import pte_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [NFRONT-1:0]     en,
	input  logic                  vin,
	input  logic [COORD_BITS-1:0] col,
	input  logic [COORD_BITS-1:0] row,
	input  pte_rgb_t              pix,
	input  mode_t                 mode,
	input  logic [CTR_W-1:0]      ccol,
	input  logic [CTR_W-1:0]      crow,
	input  logic [RATIO_W-1:0]    ratio,
	input  logic                  scale,
	output logic [NFRONT-1:0]     vout,
	output pte_item_t             item
);
	logic [NFRONT-1:0] v_q;
	logic [AX_W-1:0]   ax_s1, ay_s1, cc, cr, pc, pr;
	logic [SC_W-1:0]   sx_s2, sy_s2, ax_sc, ay_sc, ax_sh, ay_sh;
	logic [SQ_W-1:0]   sqx_s3, sqy_s3;
	logic [SQ_W:0]     sum;
	logic [D_W-1:0]    d;
	pte_rgb_t          pix_s1, pix_s2, pix_s3, alt_s1, alt_s2, alt_s3, alt_c;

	assign cc = AX_W'(ccol);
	assign cr = AX_W'(crow);
	assign pc = AX_W'(col);
	assign pr = AX_W'(row);

	always_comb begin
		alt_c = pix;
		case (mode)
			MODE_SEPIA: begin
				alt_c.blue  = sepia_ch(SEP_B_R, SEP_B_G, SEP_B_B, pix.red, pix.green, pix.blue);
				alt_c.green = sepia_ch(SEP_G_R, SEP_G_G, SEP_G_B, pix.red, pix.green, pix.blue);
				alt_c.red   = sepia_ch(SEP_R_R, SEP_R_G, SEP_R_B, pix.red, pix.green, pix.blue);
			end
			MODE_WOODCUT: begin
				alt_c.blue  = woodcut(pix.red, pix.green, pix.blue);
				alt_c.green = alt_c.blue;
				alt_c.red   = alt_c.blue;
			end
			default: alt_c = pix;
		endcase
	end

	assign ax_sc = SC_W'(ax_s1) * SC_W'(ratio);
	assign ay_sc = SC_W'(ay_s1) * SC_W'(ratio);
	assign ax_sh = {ax_s1, 16'b0, {(SC_W - AX_W - 16){1'b0}}} >> (SC_W - AX_W - 16);
	assign ay_sh = {ay_s1, 16'b0, {(SC_W - AX_W - 16){1'b0}}} >> (SC_W - AX_W - 16);
	assign sum   = (SQ_W + 1)'(sqx_s3) + (SQ_W + 1)'(sqy_s3);
	assign d     = sum[SQ_W:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= vin;
			for (int i = 1; i < NFRONT; i++) begin
				if (en[i]) v_q[i] <= v_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ax_s1  <= (cc >= pc) ? cc - pc : pc - cc;
			ay_s1  <= (cr >= pr) ? cr - pr : pr - cr;
			pix_s1 <= pix;
			alt_s1 <= alt_c;
		end
		if (en[1]) begin
			sx_s2  <= scale ? ax_sc : ax_sh;
			sy_s2  <= scale ? ay_sh : ay_sc;
			pix_s2 <= pix_s1;
			alt_s2 <= alt_s1;
		end
		if (en[2]) begin
			sqx_s3 <= SQ_W'(sx_s2) * SQ_W'(sx_s2);
			sqy_s3 <= SQ_W'(sy_s2) * SQ_W'(sy_s2);
			pix_s3 <= pix_s2;
			alt_s3 <= alt_s2;
		end
		if (en[3]) begin
			item.pix <= pix_s3;
			item.alt <= alt_s3;
			item.rem <= {d, 8'b0} - REM_W'(d);
			item.quo <= '0;
			item.sat <= 1'b0;
		end
	end

	assign vout = v_q;
endmodule

[design/pte_div_cell.sv]
// one cell of the divider chain: one quotient bit or the saturation test
`timescale 1ns / 1ps
module pte_div_cell import pte_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             sat_cell,
	input  logic [REM_W-1:0] dsh,
	input  logic             vin,
	input  pte_item_t        din,
	output logic             vout,
	output pte_item_t        dout
);
	logic      ge;
	pte_item_t nxt;

	assign ge = din.rem >= dsh;

	always_comb begin
		nxt = din;
		if (sat_cell) begin
			nxt.sat = ge;
		end else begin
			nxt.quo = {din.quo[6:0], ge & ~din.sat};
			if (ge && !din.sat) nxt.rem = din.rem - dsh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) dout <= nxt;
	end
endmodule

[design/pte_checker.sv]
// port checker for the pixel tone effect engine and its bind
`timescale 1ns / 1ps
`include "pixel_tone_effect_engine_macros.svh"
module pte_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	`PTE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
	`PTE_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)
	`PTE_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid)
	`PTE_ASSERT(a_drain_ready, out_valid && out_ready |-> in_ready)
endmodule

bind pixel_tone_effect_engine pte_checker u_pte_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (pix_in.ready),
	.out_valid(pix_out.valid),
	.out_ready(pix_out.ready)
);
